>>> hdl/mapl_pkg.sv
// mapl_pkg: word types, opcodes, sequencer states and rectangle helpers
// for the monitor-at-point lookup block. No dependencies.
`timescale 1ns / 1ps

package mapl_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LRD,
    ST_LCMP,
    ST_LWR,
    ST_QCACHE,
    ST_QRD,
    ST_QSX,
    ST_QSY,
    ST_QCMP,
    ST_QFIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    opcode_e            opcode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        [15:0] rect_width;
    logic        [15:0] rect_height;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic        [15:0] out_width;
    logic        [15:0] out_height;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [15:0] w;
    logic        [15:0] h;
  } rect_t;

  // origin -1,-1 with zero size: contains nothing
  localparam rect_t CacheEmpty = '{x: '1, y: '1, w: '0, h: '0};

  // point-in-rectangle at 18 bits, no wrap; zero size never hits
  function automatic logic rect_hit(logic signed [15:0] px, logic signed [15:0] py,
                                    rect_t r);
    logic signed [17:0] p_x, p_y, x0, y0, x1, y1;
    p_x = 18'(px);
    p_y = 18'(py);
    x0  = 18'(r.x);
    y0  = 18'(r.y);
    x1  = x0 + $signed({2'b00, r.w});
    y1  = y0 + $signed({2'b00, r.h});
    return (p_x >= x0) && (p_x < x1) && (p_y >= y0) && (p_y < y1);
  endfunction

  // point minus rectangle center along one axis; fits 18 signed bits
  function automatic logic signed [17:0] center_delta(logic signed [15:0] p,
                                                      logic signed [15:0] o,
                                                      logic [15:0] s);
    logic signed [17:0] c;
    c = 18'(o) + $signed({3'b000, s[15:1]});
    return 18'(p) - c;
  endfunction

endpackage

>>> hdl/monitor_at_point_lookup.sv
// monitor_at_point_lookup: monitor rectangle table with point query,
// one shared squaring multiplier under a small sequencer. Uses mapl_pkg.
`timescale 1ns / 1ps

// Keeps up to MAX_MONITORS monitor rectangles plus a one-rectangle cache.
// Words arrive on a valid/stall channel; only a query produces an output word.
// Clear acts in the accept cycle. Load walks the kept entries for an origin
// clone, two steps per entry (table read port, then compare), and drops the
// word on a clone; else it appends the rectangle. A load to a full table is
// dropped in the accept cycle. A query first checks the cache; on a miss it
// scans the kept entries in four steps per entry (read, square dx, square dy,
// sum and compare), all squares going through one 18x18 multiplier, stopping
// early at a containing entry; then it updates the cache and hands the word to
// the output register. The scan loop through the shared multiplier sets the
// length of a miss. The block takes no new word while it works, but a finished
// output word waiting in its register does not hold off the next input word.
// The table needs no clearing after reset: only entries below the kept count
// are read.
module monitor_at_point_lookup #(
  parameter int MAX_MONITORS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mapl_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mapl_pkg::out_word_t out_word_o
);
  import mapl_pkg::*;

  localparam int CW = $clog2(MAX_MONITORS + 1);
  localparam int AW = (MAX_MONITORS > 1) ? $clog2(MAX_MONITORS) : 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_MONITORS);

  state_e state_q, state_d;

  // captured input word
  opcode_e            op_q;
  logic signed [15:0] px_q, py_q;
  logic        [15:0] w_q, h_q;

  logic [CW-1:0] kept_q;
  logic [CW-1:0] idx_q;
  logic [CW-1:0] idx_nxt;

  rect_t cache_q;
  rect_t rd_q;     // registered table read data
  rect_t pick_q;   // best entry so far
  rect_t tbl [MAX_MONITORS];

  // distance datapath
  logic signed [17:0] mul_op;
  logic signed [35:0] sq_full;
  logic        [33:0] prod_q, acc_q;
  logic        [34:0] best_q, dist_sum;
  logic               have_q;

  out_word_t res_q;
  out_word_t out_q;
  logic      out_valid_q;

  logic in_acc, wr_en, cache_hit, scan_hit, clone, out_free, use_dx;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign idx_nxt   = idx_q + CW'(1);
  assign cache_hit = rect_hit(px_q, py_q, cache_q);
  assign scan_hit  = rect_hit(px_q, py_q, rd_q);
  assign clone     = (rd_q.x == px_q) && (rd_q.y == py_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign dist_sum  = {1'b0, acc_q} + {1'b0, prod_q};

  // shared squaring unit: dx in QSX, dy in QSY
  assign mul_op  = use_dx ? center_delta(px_q, rd_q.x, rd_q.w)
                          : center_delta(py_q, rd_q.y, rd_q.h);
  assign sq_full = mul_op * mul_op;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_word_i.opcode)
            OP_LOAD:  if (kept_q < MaxCnt) state_d = ST_LRD;
            OP_QUERY: state_d = ST_QCACHE;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_LRD:    state_d = (idx_q == kept_q) ? ST_LWR : ST_LCMP;
      ST_LCMP:   state_d = clone ? ST_IDLE : ST_LRD;
      ST_LWR:    state_d = ST_IDLE;
      ST_QCACHE: state_d = (cache_hit || kept_q == '0) ? ST_OUT : ST_QRD;
      ST_QRD:    state_d = ST_QSX;
      ST_QSX:    state_d = scan_hit ? ST_QFIN : ST_QSY;
      ST_QSY:    state_d = ST_QCMP;
      ST_QCMP:   state_d = (idx_nxt == kept_q) ? ST_QFIN : ST_QRD;
      ST_QFIN:   state_d = ST_OUT;
      ST_OUT:    state_d = out_free ? ST_IDLE : ST_OUT;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    wr_en      = (state_q == ST_LWR);
    use_dx     = (state_q == ST_QSX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl[kept_q[AW-1:0]] <= '{x: px_q, y: py_q, w: w_q, h: h_q};
    end
    rd_q <= tbl[idx_q[AW-1:0]];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q  <= '0;
      idx_q   <= '0;
      have_q  <= 1'b0;
      cache_q <= CacheEmpty;
    end else begin
      case (state_q)
        ST_IDLE: begin
          idx_q  <= '0;
          have_q <= 1'b0;
          if (in_acc && in_word_i.opcode == OP_CLEAR) begin
            kept_q  <= '0;
            cache_q <= CacheEmpty;
          end
        end
        ST_LCMP: if (!clone) idx_q <= idx_nxt;
        ST_LWR:  kept_q <= kept_q + CW'(1);
        ST_QCACHE: begin
          if (!cache_hit && kept_q == '0) cache_q <= CacheEmpty;
        end
        ST_QCMP: begin
          if (!have_q || dist_sum < best_q) have_q <= 1'b1;
          idx_q <= idx_nxt;
        end
        ST_QFIN: cache_q <= pick_q;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_q <= in_word_i.opcode;
          px_q <= in_word_i.pos_x;
          py_q <= in_word_i.pos_y;
          w_q  <= in_word_i.rect_width;
          h_q  <= in_word_i.rect_height;
        end
      end
      ST_QCACHE: begin
        if (cache_hit) begin
          res_q <= '{found: 1'b1, out_x: cache_q.x, out_y: cache_q.y,
                     out_width: cache_q.w, out_height: cache_q.h};
        end else begin
          res_q <= '0;
        end
      end
      ST_QSX: begin
        prod_q <= sq_full[33:0];
        if (scan_hit) pick_q <= rd_q;
      end
      ST_QSY: begin
        acc_q  <= prod_q;
        prod_q <= sq_full[33:0];
      end
      ST_QCMP: begin
        if (!have_q || dist_sum < best_q) begin
          best_q <= dist_sum;
          pick_q <= rd_q;
        end
      end
      ST_QFIN: begin
        res_q <= '{found: 1'b1, out_x: pick_q.x, out_y: pick_q.y,
                   out_width: pick_q.w, out_height: pick_q.h};
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // only a query reaches the output state; op_q kept for this check
  a_out_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT |-> op_q == OP_QUERY)
    else $error("output state reached by a non-query word");

  a_kept_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= MaxCnt)
    else $error("kept count above table depth");

  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QSX || state_q == ST_QSY || state_q == ST_QCMP) |-> idx_q < kept_q)
    else $error("scan index beyond kept entries");

  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("output word raised outside the output state");

endmodule
